/* sv/iba_pkg.sv */
// ----------------------------------------------------------------------------
// iba_pkg
// Shared types and constants of the indexed block allocator: sizes, request
// modes, result codes and the command/status bundles between its controller
// and its datapath.
// ----------------------------------------------------------------------------
package iba_pkg;

  localparam int BLOCKS = 16;
  localparam int FILES  = 16;

  localparam int BLK_W  = $clog2(BLOCKS);
  localparam int FILE_W = $clog2(FILES);
  localparam int CNT_W  = $clog2(BLOCKS + 1);

  localparam int MODE_W = 2;
  localparam int FID_W  = 4;
  localparam int SIZE_W = 5;
  localparam int STAT_W = 3;
  localparam int BIDX_W = 4;
  localparam int PART_W = 4;
  localparam int FREE_W = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_LIST   = 2'd2,
    MODE_COUNT  = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_EXISTS  = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_MISSING = 3'd3,
    ST_BADSIZE = 3'd4
  } status_t;

  typedef struct packed {
    logic    load;        // capture the request, clear the part counter
    logic    emit_single; // one result carrying code, no block, free count
    status_t code;
    logic    alloc_step;  // take the lowest free block for the next part
    logic    rd_start;    // begin walking the file's index page
    logic    del_free;    // free the block read back from the page
    logic    del_close;   // drop the file's entry
    logic    list_emit;   // report the block read back from the page
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  fid_bad;
    logic  file_found;
    logic  size_zero;
    logic  size_over;
    logic  alloc_last;
    logic  rd_valid;
    logic  rd_last;
  } sts_t;

endpackage

/* sv/iba_ctrl.sv */
// ----------------------------------------------------------------------------
// iba_ctrl
// Request sequencer: checks a captured request, then drives allocation,
// page walks for delete and list, and the single-result replies.
// ----------------------------------------------------------------------------
module iba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  iba_pkg::sts_t sts,
  output iba_pkg::cmd_t cmd
);
  import iba_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_ALLOC = 6'b000100,
    S_DEL   = 6'b001000,
    S_LIST  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.code  = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = S_IDLE;
        if (sts.mode == MODE_COUNT) begin
          cmd.emit_single = 1'b1;
        end else if (sts.fid_bad) begin
          cmd.emit_single = 1'b1;
          cmd.code        = ST_MISSING;
        end else if (sts.mode == MODE_ALLOC) begin
          if (sts.file_found) begin
            cmd.emit_single = 1'b1;
            cmd.code        = ST_EXISTS;
          end else if (sts.size_zero) begin
            cmd.emit_single = 1'b1;
            cmd.code        = ST_BADSIZE;
          end else if (sts.size_over) begin
            cmd.emit_single = 1'b1;
            cmd.code        = ST_NOSPACE;
          end else begin
            state_nxt = S_ALLOC;
          end
        end else if (!sts.file_found) begin
          cmd.emit_single = 1'b1;
          cmd.code        = ST_MISSING;
        end else begin
          cmd.rd_start = 1'b1;
          state_nxt    = (sts.mode == MODE_DELETE) ? S_DEL : S_LIST;
        end
      end
      S_ALLOC: begin
        cmd.alloc_step = 1'b1;
        if (sts.alloc_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_DEL: begin
        cmd.del_free = 1'b1;
        if (sts.rd_valid && sts.rd_last) begin
          state_nxt = S_DONE;
        end
      end
      S_LIST: begin
        cmd.list_emit = 1'b1;
        if (sts.rd_valid && sts.rd_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_DONE: begin
        // free count already includes every released block
        cmd.emit_single = 1'b1;
        cmd.del_close   = 1'b1;
        state_nxt       = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/iba_dpath.sv */
// ----------------------------------------------------------------------------
// iba_dpath
// Allocator storage and result registers: occupancy map, file table, index
// page memory, free count, page read pipeline and the output beat.
// ----------------------------------------------------------------------------
module iba_dpath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [iba_pkg::MODE_W-1:0]   in_mode,
  input  logic [iba_pkg::FID_W-1:0]    in_file_id,
  input  logic [iba_pkg::SIZE_W-1:0]   in_file_size,
  input  iba_pkg::cmd_t                cmd,
  output iba_pkg::sts_t                sts,
  output logic                         out_valid,
  output logic [iba_pkg::STAT_W-1:0]   out_status,
  output logic [iba_pkg::BIDX_W-1:0]   out_block_index,
  output logic [iba_pkg::PART_W-1:0]   out_partition,
  output logic [iba_pkg::FREE_W-1:0]   out_free_blocks,
  output logic                         out_last
);
  import iba_pkg::*;

  // request
  mode_t               req_mode_r;
  logic [FID_W-1:0]    req_fid_r;
  logic [SIZE_W-1:0]   req_size_r;

  // allocator state
  logic [BLOCKS-1:0]   block_used_r;
  logic [FILES-1:0]    file_valid_r;
  logic [CNT_W-1:0]    file_len_r [FILES];
  logic [FREE_W-1:0]   free_total_r;
  logic [BLK_W-1:0]    page_mem [FILES*BLOCKS];

  // page walk
  logic [CNT_W-1:0]    idx_r;
  logic                rd_on_r;
  logic                rd_v_r;
  logic                rd_last_r;
  logic [CNT_W-1:0]    rd_part_r;
  logic [BLK_W-1:0]    rdata_r;

  // result beat
  logic                ov_r;
  status_t             ost_r;
  logic [BIDX_W-1:0]   oblk_r;
  logic [PART_W-1:0]   opart_r;
  logic [FREE_W-1:0]   ofree_r;
  logic                olast_r;

  logic [FILE_W-1:0]          fslot;
  logic [FILE_W+BLK_W-1:0]    paddr;
  logic [CNT_W-1:0]           cur_len;
  logic                       issue_last;
  logic [BLK_W-1:0]           low_free;
  logic [FREE_W-1:0]          free_after;

  assign fslot      = req_fid_r[FILE_W-1:0];
  assign paddr      = {fslot, idx_r[BLK_W-1:0]};
  assign cur_len    = file_len_r[fslot];
  assign issue_last = (idx_r == cur_len - CNT_W'(1));
  assign free_after = free_total_r - FREE_W'(req_size_r);

  // lowest free block
  always_comb begin
    low_free = '0;
    for (int i = BLOCKS - 1; i >= 0; i--) begin
      if (!block_used_r[i]) begin
        low_free = BLK_W'(i);
      end
    end
  end

  always_comb begin
    sts.mode        = req_mode_r;
    sts.fid_bad     = (int'(req_fid_r) >= FILES);
    sts.file_found  = file_valid_r[fslot];
    sts.size_zero   = (req_size_r == '0);
    sts.size_over   = (FREE_W'(req_size_r) > free_total_r);
    sts.alloc_last  = (idx_r == CNT_W'(req_size_r - SIZE_W'(1)));
    sts.rd_valid    = rd_v_r;
    sts.rd_last     = rd_last_r;
  end

  // request capture, counter and read pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_on_r <= 1'b0;
      rd_v_r  <= 1'b0;
    end else begin
      rd_v_r <= 1'b0;
      if (cmd.load) begin
        req_mode_r <= mode_t'(in_mode);
        req_fid_r  <= in_file_id;
        req_size_r <= in_file_size;
        idx_r      <= '0;
      end else if (cmd.alloc_step) begin
        idx_r <= idx_r + CNT_W'(1);
      end else if (cmd.rd_start) begin
        idx_r   <= '0;
        rd_on_r <= 1'b1;
      end else if (rd_on_r) begin
        rd_v_r    <= 1'b1;
        rd_last_r <= issue_last;
        rd_part_r <= idx_r;
        idx_r     <= idx_r + CNT_W'(1);
        if (issue_last) begin
          rd_on_r <= 1'b0;
        end
      end
    end
  end

  // index page memory
  always_ff @(posedge clk) begin
    if (cmd.alloc_step) begin
      page_mem[paddr] <= low_free;
    end
    rdata_r <= page_mem[paddr];
  end

  // file lengths: written on allocation only
  always_ff @(posedge clk) begin
    if (cmd.alloc_step && sts.alloc_last) begin
      file_len_r[fslot] <= CNT_W'(req_size_r);
    end
  end

  // occupancy, file table and free count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_used_r <= '0;
      file_valid_r <= '0;
      free_total_r <= FREE_W'(BLOCKS);
    end else begin
      if (cmd.alloc_step) begin
        block_used_r[low_free] <= 1'b1;
        if (sts.alloc_last) begin
          file_valid_r[fslot] <= 1'b1;
          free_total_r        <= free_after;
        end
      end
      if (cmd.del_free && rd_v_r && block_used_r[rdata_r]) begin
        block_used_r[rdata_r] <= 1'b0;
        free_total_r          <= free_total_r + FREE_W'(1);
      end
      if (cmd.del_close) begin
        file_valid_r[fslot] <= 1'b0;
      end
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      if (cmd.emit_single) begin
        ov_r    <= 1'b1;
        ost_r   <= cmd.code;
        oblk_r  <= '0;
        opart_r <= '0;
        ofree_r <= free_total_r;
        olast_r <= 1'b1;
      end else if (cmd.alloc_step) begin
        ov_r    <= 1'b1;
        ost_r   <= ST_OK;
        oblk_r  <= BIDX_W'(low_free);
        opart_r <= PART_W'(idx_r);
        ofree_r <= free_after;
        olast_r <= sts.alloc_last;
      end else if (cmd.list_emit && rd_v_r) begin
        ov_r    <= 1'b1;
        ost_r   <= ST_OK;
        oblk_r  <= BIDX_W'(rdata_r);
        opart_r <= PART_W'(rd_part_r);
        ofree_r <= free_total_r;
        olast_r <= rd_last_r;
      end
    end
  end

  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_block_index = oblk_r;
  assign out_partition   = opart_r;
  assign out_free_blocks = ofree_r;
  assign out_last        = olast_r;

endmodule

/* sv/indexed_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// indexed_block_allocator_unit
// Indexed block allocator: occupancy map of storage blocks plus one index
// page per file, serving allocate, delete, list and free-count requests.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the request is finished. Each result is presented for exactly one
// cycle with out_valid high and must be taken then, as the block cannot be
// stalled; out_last marks the final result of a request. A count request or
// any rejection gives its single result from the check state; that result is
// registered and appears as the block returns to idle. An allocation of n
// blocks passes the check state and then allocates its parts in order. A
// delete or list of an n-part file passes the check state and then reads its
// n page entries in order through the registered index page memory; a delete
// ends in a closing state that drops the file and gives its single result.
// ----------------------------------------------------------------------------
module indexed_block_allocator_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [iba_pkg::MODE_W-1:0]   in_mode,
  input  logic [iba_pkg::FID_W-1:0]    in_file_id,
  input  logic [iba_pkg::SIZE_W-1:0]   in_file_size,
  output logic                         out_valid,
  output logic [iba_pkg::STAT_W-1:0]   out_status,
  output logic [iba_pkg::BIDX_W-1:0]   out_block_index,
  output logic [iba_pkg::PART_W-1:0]   out_partition,
  output logic [iba_pkg::FREE_W-1:0]   out_free_blocks,
  output logic                         out_last
);
  import iba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  iba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  iba_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mode         (in_mode),
    .in_file_id      (in_file_id),
    .in_file_size    (in_file_size),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_block_index (out_block_index),
    .out_partition   (out_partition),
    .out_free_blocks (out_free_blocks),
    .out_last        (out_last)
  );

endmodule

/* tb/indexed_block_allocator_unit_tb.sv */
// ----------------------------------------------------------------------------
// indexed_block_allocator_unit_tb
// Self-checking bench for the indexed block allocator. Requests come from a
// queue that a stimulus block fills: first a directed set of corner cases and
// then random allocate, delete, list and count requests in phases with and
// without sender gaps. A predictor keeps its own occupancy map and index pages,
// turns each accepted request into the results it should produce, and the
// monitor checks every result beat against the oldest of them.
// ----------------------------------------------------------------------------
module indexed_block_allocator_unit_tb;
  import iba_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 30;

  typedef struct {
    mode_t             mode;
    logic [FID_W-1:0]  fid;
    logic [SIZE_W-1:0] size;
    int                gap_pct;
    bit                hold;    // wait for all results before this beat
  } request_t;

  typedef struct {
    status_t           status;
    logic [BIDX_W-1:0] block_index;
    logic [PART_W-1:0] partition;
    logic [FREE_W-1:0] free_blocks;
    logic              last;
  } part_result_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [MODE_W-1:0]   in_mode;
  logic [FID_W-1:0]    in_file_id;
  logic [SIZE_W-1:0]   in_file_size;
  logic                out_valid;
  logic [STAT_W-1:0]   out_status;
  logic [BIDX_W-1:0]   out_block_index;
  logic [PART_W-1:0]   out_partition;
  logic [FREE_W-1:0]   out_free_blocks;
  logic                out_last;

  request_t     request_q[$];
  part_result_t awaited_parts[$];
  logic         beat_taken;
  int           mismatches;
  int           quiet_cycles;

  // predictor state
  bit         block_busy[BLOCKS];
  bit         file_live[FILES];
  int         file_parts[FILES];
  int         page_map[FILES][BLOCKS];
  int         free_count;

  indexed_block_allocator_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_file_id      (in_file_id),
    .in_file_size    (in_file_size),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_block_index (out_block_index),
    .out_partition   (out_partition),
    .out_free_blocks (out_free_blocks),
    .out_last        (out_last)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic queue_part(input status_t st, input int blk, input int part,
                            input bit last);
    part_result_t r;
    r.status      = st;
    r.block_index = blk[BIDX_W-1:0];
    r.partition   = part[PART_W-1:0];
    r.free_blocks = free_count[FREE_W-1:0];
    r.last        = last;
    awaited_parts.insert(awaited_parts.size(), r);
  endtask

  // Update the allocator state for one accepted request and queue its results.
  task automatic serve_request(input mode_t mode, input int fid, input int size);
    int b;
    int i;
    b = 0;
    if (mode == MODE_COUNT) begin
      queue_part(ST_OK, 0, 0, 1'b1);
    end else if (fid >= FILES) begin
      queue_part(ST_MISSING, 0, 0, 1'b1);
    end else if (mode == MODE_ALLOC) begin
      if (file_live[fid]) queue_part(ST_EXISTS, 0, 0, 1'b1);
      else if (size == 0) queue_part(ST_BADSIZE, 0, 0, 1'b1);
      else if (size > free_count) queue_part(ST_NOSPACE, 0, 0, 1'b1);
      else begin
        // lowest free block for each part in turn
        for (i = 0; i < size; i++) begin
          while (b < BLOCKS && block_busy[b]) b++;
          block_busy[b] = 1'b1;
          page_map[fid][i] = b;
          free_count--;
        end
        file_live[fid]  = 1'b1;
        file_parts[fid] = size;
        for (i = 0; i < size; i++)
          queue_part(ST_OK, page_map[fid][i], i, i == size - 1);
      end
    end else if (!file_live[fid]) begin
      queue_part(ST_MISSING, 0, 0, 1'b1);
    end else if (mode == MODE_DELETE) begin
      for (i = 0; i < file_parts[fid]; i++) begin
        if (block_busy[page_map[fid][i]]) begin
          block_busy[page_map[fid][i]] = 1'b0;
          free_count++;
        end
      end
      file_live[fid]  = 1'b0;
      file_parts[fid] = 0;
      queue_part(ST_OK, 0, 0, 1'b1);
    end else begin
      for (i = 0; i < file_parts[fid]; i++)
        queue_part(ST_OK, page_map[fid][i], i, i == file_parts[fid] - 1);
    end
  endtask

  task automatic add_request(input mode_t mode, input int fid, input int size,
                             input int gap_pct, input bit hold);
    request_t r;
    r.mode    = mode;
    r.fid     = fid[FID_W-1:0];
    r.size    = size[SIZE_W-1:0];
    r.gap_pct = gap_pct;
    r.hold    = hold;
    request_q.insert(request_q.size(), r);
  endtask

  // Driver: change inputs at the falling edge only.
  always @(negedge clk) begin : drive_requests
    request_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || beat_taken) begin
      if (request_q.size() == 0) begin
        start <= 1'b0;
      end else if (request_q[0].hold && (awaited_parts.size() != 0 || busy)) begin
        start <= 1'b0;
      end else if ($urandom_range(99) < request_q[0].gap_pct) begin
        start <= 1'b0;
      end else begin
        nxt = request_q.pop_front();
        in_mode      <= nxt.mode;
        in_file_id   <= nxt.fid;
        in_file_size <= nxt.size;
        start        <= 1'b1;
      end
    end
  end

  // Monitor: check result beats first, then predict for a newly taken request.
  always @(posedge clk) begin : watch_results
    part_result_t exp_r;
    bit           active;
    active = 1'b0;
    beat_taken <= rst_n && start && !busy;
    if (rst_n && out_valid) begin
      active = 1'b1;
      if (awaited_parts.size() == 0) begin
        flag_mismatch("result beat with nothing awaited");
      end else begin
        exp_r = awaited_parts.pop_front();
        if (out_status !== exp_r.status)
          flag_mismatch($sformatf("status %0d, expected %0d", out_status, exp_r.status));
        if (out_block_index !== exp_r.block_index)
          flag_mismatch($sformatf("block_index %0d, expected %0d",
                                  out_block_index, exp_r.block_index));
        if (out_partition !== exp_r.partition)
          flag_mismatch($sformatf("partition %0d, expected %0d",
                                  out_partition, exp_r.partition));
        if (out_free_blocks !== exp_r.free_blocks)
          flag_mismatch($sformatf("free_blocks %0d, expected %0d",
                                  out_free_blocks, exp_r.free_blocks));
        if (out_last !== exp_r.last)
          flag_mismatch($sformatf("last %0b, expected %0b", out_last, exp_r.last));
      end
    end
    if (rst_n && start && !busy) begin
      active = 1'b1;
      serve_request(mode_t'(in_mode), int'(in_file_id), int'(in_file_size));
    end
    quiet_cycles = active ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    int n;
    int r;
    int gap;
    int fid;
    int size;
    mode_t mode;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_mode      = '0;
    in_file_id   = '0;
    in_file_size = '0;
    beat_taken   = 1'b0;
    mismatches   = 0;
    quiet_cycles = 0;
    free_count   = BLOCKS;
    for (int i = 0; i < FILES; i++) begin
      file_live[i]  = 1'b0;
      file_parts[i] = 0;
    end
    for (int i = 0; i < BLOCKS; i++) block_busy[i] = 1'b0;

    // directed corners
    add_request(MODE_COUNT,  0,  0, 0, 0);
    add_request(MODE_LIST,   0,  0, 0, 0);
    add_request(MODE_DELETE, 15, 31, 0, 0);
    add_request(MODE_ALLOC,  0,  0, 0, 0);
    add_request(MODE_ALLOC,  0,  31, 0, 0);
    add_request(MODE_ALLOC,  0,  17, 0, 0);
    add_request(MODE_ALLOC,  0,  16, 0, 0);
    add_request(MODE_COUNT,  9,  21, 0, 0);
    add_request(MODE_ALLOC,  1,  1, 0, 0);
    add_request(MODE_ALLOC,  0,  3, 0, 0);
    add_request(MODE_ALLOC,  0,  0, 0, 0);
    add_request(MODE_LIST,   0,  10, 0, 0);
    add_request(MODE_DELETE, 0,  0, 0, 0);
    add_request(MODE_DELETE, 0,  0, 0, 0);
    add_request(MODE_ALLOC,  15, 1, 0, 0);
    add_request(MODE_ALLOC,  3,  5, 0, 0);
    add_request(MODE_ALLOC,  7,  2, 0, 0);
    add_request(MODE_DELETE, 3,  0, 0, 0);
    add_request(MODE_ALLOC,  9,  7, 0, 0);
    add_request(MODE_LIST,   9,  0, 0, 0);
    add_request(MODE_LIST,   15, 0, 0, 0);
    add_request(MODE_ALLOC,  12, 16, 0, 0);
    add_request(MODE_DELETE, 15, 0, 0, 0);
    add_request(MODE_DELETE, 7,  0, 0, 0);
    add_request(MODE_DELETE, 9,  0, 0, 0);

    // random phases: no gaps, heavy sender gaps, light sender gaps
    for (n = 0; n < 280; n++) begin
      gap = (n < 90) ? 0 : (n < 180) ? 55 : 13;
      r = $urandom_range(99);
      mode = (r < 40) ? MODE_ALLOC : (r < 65) ? MODE_DELETE :
             (r < 85) ? MODE_LIST : MODE_COUNT;
      // keep most traffic on a few files so deletes and lists find them
      fid = ($urandom_range(99) < 75) ? $urandom_range(7) : $urandom_range(FILES - 1);
      r = $urandom_range(99);
      size = (r < 8)  ? 0 :
             (r < 78) ? $urandom_range(5, 1) :
             (r < 92) ? $urandom_range(BLOCKS, 6) : $urandom_range(31, BLOCKS + 1);
      add_request(mode, fid, size, gap,
                  (n == 0 || n == 90 || n == 180 || $urandom_range(99) < 4));
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || start || awaited_parts.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_parts.size() != 0)
      flag_mismatch($sformatf("%0d result beats never arrived", awaited_parts.size()));
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

/* files.f */
sv/iba_pkg.sv
sv/iba_ctrl.sv
sv/iba_dpath.sv
sv/indexed_block_allocator_unit.sv
tb/indexed_block_allocator_unit_tb.sv
